// File: hw/rtl/shpc_pkg.sv
`default_nettype none
package shpc_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned EpsWidth   = CoordWidth - 1;
   localparam int unsigned DiffWidth  = CoordWidth + 1;
   localparam int unsigned DistWidth  = 2 * DiffWidth + 1;
   localparam int unsigned ProdWidth  = DistWidth + CoordWidth;
   localparam int unsigned NumWidth   = ProdWidth + 1;
   localparam int unsigned DenWidth   = DistWidth + 1;
   localparam int unsigned QuoWidth   = NumWidth;
   localparam int unsigned Stages     = QuoWidth;

   typedef enum logic [1:0] {
      REGION_IN  = 2'd0,
      REGION_ON  = 2'd1,
      REGION_OUT = 2'd2
   } region_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] normal_x;
      logic signed [CoordWidth-1:0] normal_y;
      logic signed [CoordWidth-1:0] ref_x;
      logic signed [CoordWidth-1:0] ref_y;
      logic        [EpsWidth-1:0]   half_thickness;
      logic signed [CoordWidth-1:0] first_x;
      logic signed [CoordWidth-1:0] first_y;
      logic signed [CoordWidth-1:0] second_x;
      logic signed [CoordWidth-1:0] second_y;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] out_first_x;
      logic signed [CoordWidth-1:0] out_first_y;
      logic signed [CoordWidth-1:0] out_second_x;
      logic signed [CoordWidth-1:0] out_second_y;
      logic                         success;
      logic        [1:0]            first_region;
      logic        [1:0]            second_region;
   } rsp_type;

   // one division lane travelling down the chain
   typedef struct packed {
      logic [QuoWidth-1:0] rem;
      logic [QuoWidth-1:0] num;
      logic [DenWidth-1:0] den;
      logic [QuoWidth-1:0] quo;
      logic                neg;
   } lane_type;

   // item carried alongside the lanes
   typedef struct packed {
      logic                    valid;
      rsp_type                 rsp;
      logic                    move_x1;
      logic                    move_x2;
   } ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/segment_half_plane_clip.sv
// Five front stages (difference, distance product, sum, split products, recombine),
// then one restoring divider cell per quotient bit, then the output register.
// Throughput: one segment per cycle; busy stays low. Reset (synchronous, active high)
// clears all valid flags; the receiver cannot stall, each result strobes for one cycle.
`default_nettype none
module segment_half_plane_clip (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire shpc_pkg::req_type req_data,
   output logic                   rsp_valid,
   output shpc_pkg::rsp_type      rsp_data
);
   localparam int unsigned N  = shpc_pkg::Stages;
   localparam int unsigned QW = shpc_pkg::QuoWidth;
   localparam int unsigned CW = shpc_pkg::CoordWidth;
   localparam int unsigned IW = $clog2(QW);

   shpc_pkg::ctl_type  ctl [N+1];
   shpc_pkg::lane_type lx [N+1];
   shpc_pkg::lane_type ly [N+1];
   logic               rsp_valid_ff;
   shpc_pkg::rsp_type  rsp_ff, rsp_in;

   assign busy = 1'b0;

   shpc_front u_front (
      .clock(clock), .reset(reset), .valid_i(start), .req_i(req_data),
      .ctl_o(ctl[0]), .lane_x_o(lx[0]), .lane_y_o(ly[0])
   );

   // chain of division cells, most significant bit first
   for (genvar g = 0; g < N; g++) begin : g_cell
      shpc_cell u_cell (
         .clock(clock), .reset(reset), .bit_idx(IW'(QW - 1 - g)),
         .ctl_i(ctl[g]), .lane_x_i(lx[g]), .lane_y_i(ly[g]),
         .ctl_o(ctl[g+1]), .lane_x_o(lx[g+1]), .lane_y_o(ly[g+1])
      );
   end

   function automatic logic [CW-1:0] sat(shpc_pkg::lane_type l);
      logic [QW-1:0] half;
      logic [CW-1:0] r;
      half = QW'(1) << (CW - 1);
      if (l.neg) r = (l.quo > half) ? half[CW-1:0] : CW'(-l.quo);
      else       r = (l.quo > half - QW'(1)) ? CW'(half - QW'(1)) : l.quo[CW-1:0];
      return r;
   endfunction

   // saturate and place the moved end point
   always_comb begin
      rsp_in = ctl[N].rsp;
      if (ctl[N].move_x1) begin
         rsp_in.out_first_x = sat(lx[N]);
         rsp_in.out_first_y = sat(ly[N]);
      end
      if (ctl[N].move_x2) begin
         rsp_in.out_second_x = sat(lx[N]);
         rsp_in.out_second_y = sat(ly[N]);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl[N].valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_dual_move: assert property (@(posedge clock) disable iff (reset)
      ctl[N].valid |-> !(ctl[N].move_x1 && ctl[N].move_x2)) else $error("both ends moved");
   a_fail_nomove: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.success |-> rsp_ff.first_region == shpc_pkg::REGION_OUT)
      else $error("failure without out point");
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff) else $error("result after reset");
endmodule
`default_nettype wire

// File: hw/rtl/shpc_cell.sv
`default_nettype none
module shpc_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [$clog2(shpc_pkg::QuoWidth)-1:0] bit_idx,
   input  wire shpc_pkg::ctl_type  ctl_i,
   input  wire shpc_pkg::lane_type lane_x_i,
   input  wire shpc_pkg::lane_type lane_y_i,
   output shpc_pkg::ctl_type       ctl_o,
   output shpc_pkg::lane_type      lane_x_o,
   output shpc_pkg::lane_type      lane_y_o
);
   shpc_pkg::ctl_type  ctl_ff;
   shpc_pkg::lane_type x_ff, y_ff, x_in, y_in;

   function automatic shpc_pkg::lane_type step(shpc_pkg::lane_type l,
                                               logic [$clog2(shpc_pkg::QuoWidth)-1:0] i);
      shpc_pkg::lane_type r;
      logic [shpc_pkg::QuoWidth:0] t;
      r = l;
      t = {l.rem, l.num[i]};
      if (t >= {{(shpc_pkg::QuoWidth + 1 - shpc_pkg::DenWidth){1'b0}}, l.den}) begin
         t = t - {{(shpc_pkg::QuoWidth + 1 - shpc_pkg::DenWidth){1'b0}}, l.den};
         r.quo[i] = 1'b1;
      end
      r.rem = t[shpc_pkg::QuoWidth-1:0];
      return r;
   endfunction

   // one restoring step per lane
   always_comb begin
      x_in = step(lane_x_i, bit_idx);
      y_in = step(lane_y_i, bit_idx);
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      ctl_ff.rsp <= ctl_i.rsp;
      ctl_ff.move_x1 <= ctl_i.move_x1;
      ctl_ff.move_x2 <= ctl_i.move_x2;
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_i.valid;
      end
   end

   assign ctl_o = ctl_ff;
   assign lane_x_o = x_ff;
   assign lane_y_o = y_ff;
endmodule
`default_nettype wire

// File: hw/rtl/shpc_front.sv
`default_nettype none
module shpc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              valid_i,
   input  wire shpc_pkg::req_type req_i,
   output shpc_pkg::ctl_type      ctl_o,
   output shpc_pkg::lane_type     lane_x_o,
   output shpc_pkg::lane_type     lane_y_o
);
   localparam int unsigned CW    = shpc_pkg::CoordWidth;
   localparam int unsigned DF    = shpc_pkg::DiffWidth;
   localparam int unsigned DW    = shpc_pkg::DistWidth;
   localparam int unsigned NW    = shpc_pkg::NumWidth;
   localparam int unsigned PW    = shpc_pkg::ProdWidth;
   localparam int unsigned MW    = CW + DF;
   localparam int unsigned SPLIT = 34;
   localparam int unsigned LW    = SPLIT + 1 + CW;
   localparam int unsigned HW    = DW - SPLIT + CW;

   // stage 1: differences
   logic                 v1_ff;
   shpc_pkg::req_type    r1_ff;
   logic signed [DF-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   // stage 2: products
   logic                 v2_ff;
   shpc_pkg::req_type    r2_ff;
   logic signed [MW-1:0] px1_ff, py1_ff, px2_ff, py2_ff;
   // stage 3: distances
   logic                 v3_ff;
   shpc_pkg::req_type    r3_ff;
   logic signed [DW-1:0] d1_ff, d2_ff;
   // stage 4: partial numerator products, distance split in a low and a high part
   logic                 v4_ff;
   shpc_pkg::req_type    r4_ff;
   logic signed [DW-1:0] d1b_ff, d2b_ff;
   logic signed [LW-1:0] pxl_ff, pyl_ff, qxl_ff, qyl_ff;
   logic signed [HW-1:0] pxh_ff, pyh_ff, qxh_ff, qyh_ff;
   // stage 5: full numerator products, classes and denominator
   logic                 v5_ff;
   shpc_pkg::req_type    r5_ff;
   logic signed [PW-1:0] px_ff, py_ff, qx_ff, qy_ff;
   logic [1:0]           rg1_ff, rg2_ff;
   logic signed [shpc_pkg::DenWidth-1:0] den_ff;

   logic signed [DW-1:0] eps;
   logic mv1, mv2;
   logic signed [NW-1:0] nx, ny;
   logic signed [shpc_pkg::DenWidth-1:0] den;

   function automatic logic [1:0] classify(logic signed [DW-1:0] d,
                                           logic signed [DW-1:0] e);
      logic [1:0] c;
      if (d > e) c = shpc_pkg::REGION_OUT;
      else if (d >= -e) c = shpc_pkg::REGION_ON;
      else c = shpc_pkg::REGION_IN;
      return c;
   endfunction

   function automatic shpc_pkg::lane_type mk(logic signed [NW-1:0] n,
                                             logic signed [shpc_pkg::DenWidth-1:0] d);
      shpc_pkg::lane_type l;
      l.rem = '0;
      l.quo = '0;
      l.num = n[NW-1] ? shpc_pkg::QuoWidth'(-n) : shpc_pkg::QuoWidth'(n);
      l.den = d[shpc_pkg::DenWidth-1] ? -d : d;
      l.neg = n[NW-1] ^ d[shpc_pkg::DenWidth-1];
      return l;
   endfunction

   assign eps = DW'({r4_ff.half_thickness, 16'h0000});

   always_ff @(posedge clock) begin
      r1_ff  <= req_i;
      dx1_ff <= DF'(req_i.first_x)  - DF'(req_i.ref_x);
      dy1_ff <= DF'(req_i.first_y)  - DF'(req_i.ref_y);
      dx2_ff <= DF'(req_i.second_x) - DF'(req_i.ref_x);
      dy2_ff <= DF'(req_i.second_y) - DF'(req_i.ref_y);
      r2_ff  <= r1_ff;
      px1_ff <= MW'(dx1_ff) * MW'(r1_ff.normal_x);
      py1_ff <= MW'(dy1_ff) * MW'(r1_ff.normal_y);
      px2_ff <= MW'(dx2_ff) * MW'(r1_ff.normal_x);
      py2_ff <= MW'(dy2_ff) * MW'(r1_ff.normal_y);
      r3_ff  <= r2_ff;
      d1_ff  <= DW'(px1_ff) + DW'(py1_ff);
      d2_ff  <= DW'(px2_ff) + DW'(py2_ff);
      r4_ff  <= r3_ff;
      d1b_ff <= d1_ff;
      d2b_ff <= d2_ff;
      pxl_ff <= LW'($signed({1'b0, d2_ff[SPLIT-1:0]})) * LW'(r3_ff.first_x);
      pyl_ff <= LW'($signed({1'b0, d2_ff[SPLIT-1:0]})) * LW'(r3_ff.first_y);
      qxl_ff <= LW'($signed({1'b0, d1_ff[SPLIT-1:0]})) * LW'(r3_ff.second_x);
      qyl_ff <= LW'($signed({1'b0, d1_ff[SPLIT-1:0]})) * LW'(r3_ff.second_y);
      pxh_ff <= HW'($signed(d2_ff[DW-1:SPLIT])) * HW'(r3_ff.first_x);
      pyh_ff <= HW'($signed(d2_ff[DW-1:SPLIT])) * HW'(r3_ff.first_y);
      qxh_ff <= HW'($signed(d1_ff[DW-1:SPLIT])) * HW'(r3_ff.second_x);
      qyh_ff <= HW'($signed(d1_ff[DW-1:SPLIT])) * HW'(r3_ff.second_y);
      r5_ff  <= r4_ff;
      px_ff  <= (PW'(pxh_ff) <<< SPLIT) + PW'(pxl_ff);
      py_ff  <= (PW'(pyh_ff) <<< SPLIT) + PW'(pyl_ff);
      qx_ff  <= (PW'(qxh_ff) <<< SPLIT) + PW'(qxl_ff);
      qy_ff  <= (PW'(qyh_ff) <<< SPLIT) + PW'(qyl_ff);
      rg1_ff <= classify(d1b_ff, eps);
      rg2_ff <= classify(d2b_ff, eps);
      den_ff <= shpc_pkg::DenWidth'(d2b_ff) - shpc_pkg::DenWidth'(d1b_ff);
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // pick the moving end and build the division lanes
   always_comb begin
      mv1 = (rg1_ff == shpc_pkg::REGION_OUT) && (rg2_ff != shpc_pkg::REGION_OUT);
      mv2 = (rg2_ff == shpc_pkg::REGION_OUT) && (rg1_ff != shpc_pkg::REGION_OUT);
      if (mv1) begin
         nx  = NW'(px_ff) - NW'(qx_ff);
         ny  = NW'(py_ff) - NW'(qy_ff);
         den = den_ff;
      end else begin
         nx  = NW'(qx_ff) - NW'(px_ff);
         ny  = NW'(qy_ff) - NW'(py_ff);
         den = -den_ff;
      end
      lane_x_o = mk(nx, den);
      lane_y_o = mk(ny, den);
      ctl_o.valid = v5_ff;
      ctl_o.move_x1 = mv1;
      ctl_o.move_x2 = mv2;
      ctl_o.rsp.out_first_x  = r5_ff.first_x;
      ctl_o.rsp.out_first_y  = r5_ff.first_y;
      ctl_o.rsp.out_second_x = r5_ff.second_x;
      ctl_o.rsp.out_second_y = r5_ff.second_y;
      ctl_o.rsp.success = !((rg1_ff == shpc_pkg::REGION_OUT) &&
                            (rg2_ff == shpc_pkg::REGION_OUT));
      ctl_o.rsp.first_region  = rg1_ff;
      ctl_o.rsp.second_region = rg2_ff;
   end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none
module testbench;

   localparam int LATENCY = 140;
   localparam int RANDOM_ITEMS = 800;
   localparam int WIDE = 200;

   typedef logic signed [WIDE-1:0] wide_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   shpc_pkg::req_type req_data = '0;
   logic    rsp_valid;
   shpc_pkg::rsp_type rsp_data;

   shpc_pkg::rsp_type clip_queue[$];
   int      mismatches = 0;

   segment_half_plane_clip u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic wide_type plane_distance(shpc_pkg::req_type r,
                                               logic signed [31:0] px,
                                               logic signed [31:0] py);
      wide_type dx, dy;
      dx = wide_type'(px) - wide_type'(r.ref_x);
      dy = wide_type'(py) - wide_type'(r.ref_y);
      return dx * wide_type'(r.normal_x) + dy * wide_type'(r.normal_y);
   endfunction

   function automatic shpc_pkg::region_type classify_point(wide_type d, wide_type e);
      if (d > e) return shpc_pkg::REGION_OUT;
      if (d >= -e) return shpc_pkg::REGION_ON;
      return shpc_pkg::REGION_IN;
   endfunction

   // exact quotient toward zero, then saturate
   function automatic logic [31:0] move_coord(wide_type dout, logic signed [31:0] pout,
                                              wide_type doth, logic signed [31:0] poth);
      wide_type num, den, q;
      logic neg;
      num = doth * wide_type'(pout) - dout * wide_type'(poth);
      den = doth - dout;
      neg = (num < 0) != (den < 0);
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      q = num / den;
      if (neg) begin
         if (q > wide_type'(64'sh80000000)) return 32'h80000000;
         return 32'(-q);
      end
      if (q > wide_type'(64'sh7fffffff)) return 32'h7fffffff;
      return 32'(q);
   endfunction

   function automatic shpc_pkg::rsp_type clip_segment(shpc_pkg::req_type r);
      shpc_pkg::rsp_type o;
      wide_type e, d1, d2;
      shpc_pkg::region_type r1, r2;
      e = wide_type'({1'b0, r.half_thickness}) <<< 16;
      d1 = plane_distance(r, r.first_x, r.first_y);
      d2 = plane_distance(r, r.second_x, r.second_y);
      r1 = classify_point(d1, e);
      r2 = classify_point(d2, e);
      o.out_first_x = r.first_x;
      o.out_first_y = r.first_y;
      o.out_second_x = r.second_x;
      o.out_second_y = r.second_y;
      o.success = 1'b1;
      o.first_region = r1;
      o.second_region = r2;
      if (r1 != shpc_pkg::REGION_OUT && r2 == shpc_pkg::REGION_OUT) begin
         o.out_second_x = move_coord(d2, r.second_x, d1, r.first_x);
         o.out_second_y = move_coord(d2, r.second_y, d1, r.first_y);
      end else if (r1 == shpc_pkg::REGION_OUT && r2 != shpc_pkg::REGION_OUT) begin
         o.out_first_x = move_coord(d1, r.first_x, d2, r.second_x);
         o.out_first_y = move_coord(d1, r.first_y, d2, r.second_y);
      end else if (r1 == shpc_pkg::REGION_OUT && r2 == shpc_pkg::REGION_OUT) begin
         o.success = 1'b0;
      end
      return o;
   endfunction

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      shpc_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (clip_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = clip_queue.pop_front();
            if (want.out_first_x !== rsp_data.out_first_x
                || want.out_first_y !== rsp_data.out_first_y
                || want.out_second_x !== rsp_data.out_second_x
                || want.out_second_y !== rsp_data.out_second_y
                || want.success !== rsp_data.success
                || want.first_region !== rsp_data.first_region
                || want.second_region !== rsp_data.second_region) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", want, rsp_data);
            end
         end
      end
   end

   // raise start with the beat and wait for acceptance; start stays high until idle_gap drops it
   task automatic send_beat(shpc_pkg::req_type r, shpc_pkg::rsp_type want, bit typed);
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      clip_queue.push_back(typed ? want : clip_segment(r));
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   function automatic shpc_pkg::req_type rand_req();
      shpc_pkg::req_type r;
      int m;
      m = $urandom_range(0, 9);
      m = (m < 2) ? 0 : (m == 2) ? 2 : (m < 6) ? 1 : 3;
      r.normal_x = rand_coord($urandom_range(0, 4) == 0 ? 0 : 3);
      r.normal_y = rand_coord($urandom_range(0, 4) == 0 ? 0 : 3);
      r.ref_x = rand_coord(m);
      r.ref_y = rand_coord(m);
      case ($urandom_range(0, 3))
         0: r.half_thickness = '0;
         1: r.half_thickness = 31'($urandom());
         default: r.half_thickness = 31'($urandom_range(0, 1 << 18));
      endcase
      r.first_x = rand_coord(m);
      r.first_y = rand_coord(m);
      r.second_x = rand_coord(m);
      r.second_y = rand_coord(m);
      if ($urandom_range(0, 15) == 0) r.second_x = r.first_x;
      return r;
   endfunction

   typedef struct {
      shpc_pkg::req_type req;
      shpc_pkg::rsp_type rsp;
      bit                typed;
   } clip_row_type;

   function automatic clip_row_type row(logic [31:0] nx, logic [31:0] ny, logic [31:0] rx,
                                        logic [31:0] ry, logic [30:0] eps, logic [31:0] x1,
                                        logic [31:0] y1, logic [31:0] x2, logic [31:0] y2,
                                        bit typed, logic ok, shpc_pkg::region_type a,
                                        shpc_pkg::region_type b);
      clip_row_type t;
      t.req = '{nx, ny, rx, ry, eps, x1, y1, x2, y2};
      t.rsp = '{x1, y1, x2, y2, ok, a, b};
      t.typed = typed;
      return t;
   endfunction

   initial begin
      clip_row_type rows[$];
      int guard;
      localparam logic [31:0] ONE = 32'h00010000;
      localparam logic [31:0] MAXC = 32'h7fffffff;
      localparam logic [31:0] MINC = 32'h80000000;
      // zero normal: both on, nothing moves
      rows.push_back(row(0, 0, 0, 0, 0, MAXC, MINC, MINC, MAXC, 1, 1,
                         shpc_pkg::REGION_ON, shpc_pkg::REGION_ON));
      rows.push_back(row(0, 0, 5, 5, 31'h7fffffff, 1, 2, 3, 4, 1, 1,
                         shpc_pkg::REGION_ON, shpc_pkg::REGION_ON));
      // both out
      rows.push_back(row(ONE, 0, 0, 0, 0, ONE, 0, 2 * ONE, 0, 1, 0,
                         shpc_pkg::REGION_OUT, shpc_pkg::REGION_OUT));
      rows.push_back(row(MAXC, MAXC, MINC, MINC, 0, MAXC, MAXC, MAXC, MAXC, 1, 0,
                         shpc_pkg::REGION_OUT, shpc_pkg::REGION_OUT));
      // both in
      rows.push_back(row(ONE, 0, 0, 0, 0, -ONE, 0, -2 * ONE, 7, 1, 1,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));
      rows.push_back(row(MINC, MINC, MINC, MINC, 0, MAXC, MAXC, MAXC, MAXC, 1, 1,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));
      // exactly one out, either side, then an on point with an in point
      rows.push_back(row(ONE, 0, 0, 0, 0, -ONE, ONE, 3 * ONE, ONE, 0, 0,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));
      rows.push_back(row(ONE, 0, 0, 0, 0, 3 * ONE, ONE, -ONE, -ONE, 0, 0,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));
      rows.push_back(row(0, ONE, ONE, ONE, ONE, 5, 2 * ONE, MINC, MINC, 0, 0,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));
      // extrapolation past an outer-side on point, saturating
      rows.push_back(row(ONE, 0, 0, 0, ONE, ONE - 1, 0, ONE + 1, MAXC, 0, 0,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));
      rows.push_back(row(ONE, ONE, 0, 0, ONE, ONE, 0, MAXC, MINC + 5, 0, 0,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));
      rows.push_back(row(MAXC, MINC, MAXC, MINC, 31'h7fffffff, MINC, MAXC, 0, 0, 0, 0,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));
      rows.push_back(row(MINC, MAXC, 0, 0, 31'h7fffffff, MAXC, MINC, MINC, MAXC, 0, 0,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));
      // on boundaries at both signs
      rows.push_back(row(ONE, 0, 0, 0, ONE, ONE, 0, -ONE, 0, 1, 1,
                         shpc_pkg::REGION_ON, shpc_pkg::REGION_ON));
      rows.push_back(row(32'hffffffff, 32'h55555555, 32'haaaaaaaa, 32'h12345678, 31'h2aaaaaaa,
                         32'h0f0f0f0f, 32'hf0f0f0f0, 32'h33333333, 32'hcccccccc, 0, 0,
                         shpc_pkg::REGION_IN, shpc_pkg::REGION_IN));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_beat(rows[i].req, rows[i].rsp, rows[i].typed);
         idle_gap();
      end
      repeat (RANDOM_ITEMS) begin
         send_beat(rand_req(), '0, 0);
         idle_gap();
      end
      start <= 1'b0;

      guard = 0;
      while (clip_queue.size() != 0 && guard < 100 * LATENCY) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY) @(posedge clock);
      if (mismatches == 0 && clip_queue.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
